@@ design/mbrtu_pkg.sv @@
// ----------------------------------------------------------------------------
// mbrtu_pkg: shared types and constants
// Function codes, exception codes, reply command record and CRC step.
// ----------------------------------------------------------------------------
package mbrtu_pkg;

  localparam logic [7:0] FN_READ       = 8'h03;
  localparam logic [7:0] FN_WRITE      = 8'h06;
  localparam logic [7:0] FN_EXC_BIT    = 8'h80;
  localparam logic [7:0] EXC_FUNCTION  = 8'h01;
  localparam logic [7:0] EXC_RANGE     = 8'h02;
  localparam logic [7:0] EXC_LIMIT     = 8'h03;
  localparam logic [6:0] READ_LIMIT    = 7'd125;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'hA001;

  localparam logic [1:0] CFG_STATION   = 2'd0;
  localparam logic [1:0] CFG_LIM_REG   = 2'd1;
  localparam logic [1:0] CFG_LIM_MAX   = 2'd2;

  typedef enum logic [1:0] {
    KIND_EXC   = 2'd0,
    KIND_READ  = 2'd1,
    KIND_WRITE = 2'd2
  } kind_t;

  // One reply job handed from front to back.
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  func;
    logic [7:0]  code;
    logic [31:0] head;
    logic [7:0]  station;
  } cmd_t;

  typedef enum logic [2:0] {
    TX_IDLE,
    TX_HDR,
    TX_BODY,
    TX_CRC_LO,
    TX_CRC_HI
  } tx_state_t;

  function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ design/modbus_rtu_holding_register_slave.sv @@
// ----------------------------------------------------------------------------
// modbus_rtu_holding_register_slave: Modbus RTU holding register slave
// Parses request bytes, executes read/write, streams CRC-terminated replies.
// ----------------------------------------------------------------------------
// Input channel: push a request byte with in_frame_last on its final (CRC
// high) byte; the byte transfers when in_push is high and in_full is low.
// Each byte is absorbed as it transfers; the frame is judged on its last byte.
// Result channel: while out_empty is low the oldest reply byte sits on
// out_reply_byte/out_reply_last; it transfers when out_pop is high.
// A two-entry job queue sits between the parser and the reply sequencer,
// so a new frame can be received while a reply drains; in_full rises only
// when both job slots are taken and a further last byte could overflow.
// A judged frame's job is queued, then TX_HDR sends the first reply byte; then one
// byte per cycle while out_pop stays high (register reads come from a
// flop array, one word per two bytes). A stall simply holds the byte.
// A register write lands when its echo reply finishes, so every reply
// sees the store in request order.
// Configuration writes (cfg_we/cfg_index/cfg_data) take effect at once.
// Synchronous reset clears the register store, the parser and the queue.
// ----------------------------------------------------------------------------
module modbus_rtu_holding_register_slave import mbrtu_pkg::*; #(
  parameter int REG_COUNT = 16,
  parameter int MAX_FRAME = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_frame_byte,
  input  logic        in_frame_last,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [7:0]  out_reply_byte,
  output logic        out_reply_last,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  localparam int AW = $clog2(REG_COUNT);

  logic [7:0]  station_r;
  logic [3:0]  lim_reg_r;
  logic [15:0] lim_max_r;
  logic [15:0] store_r [REG_COUNT];

  logic        acc, cmd_vld, wr_en, job_pop, out_vld;
  cmd_t        cmd, job;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [15:0] wr_data;

  // job queue, two entries
  cmd_t        q_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;

  assign in_full = (cnt_r == 2'd2);
  assign acc = in_push && !in_full;

  // head job of the queue; a write job commits as its reply completes
  assign job = q_r[rp_r];
  assign wr_en = job_pop && (job.kind == KIND_WRITE);
  assign wr_addr = job.head[16 +: AW];
  assign wr_data = job.head[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      station_r <= 8'd1;
      lim_reg_r <= 4'd2;
      lim_max_r <= 16'd500;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STATION: station_r <= cfg_data[7:0];
        CFG_LIM_REG: lim_reg_r <= cfg_data[3:0];
        CFG_LIM_MAX: lim_max_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REG_COUNT; i++) store_r[i] <= '0;
    end else if (wr_en) begin
      store_r[wr_addr] <= wr_data;
    end
  end

  mbrtu_front #(.REG_COUNT(REG_COUNT), .MAX_FRAME(MAX_FRAME)) u_front (
    .clk, .rst_n, .byte_vld(acc), .frame_byte(in_frame_byte),
    .frame_last(in_frame_last), .station(station_r), .lim_reg(lim_reg_r),
    .lim_max(lim_max_r), .cmd_vld, .cmd
  );

  always_ff @(posedge clk) begin
    if (cmd_vld) q_r[wp_r] <= cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (cmd_vld) wp_r <= ~wp_r;
      if (job_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, cmd_vld} - {1'b0, job_pop};
    end
  end

  mbrtu_back #(.REG_COUNT(REG_COUNT)) u_back (
    .clk, .rst_n, .job_vld(cnt_r != 2'd0), .job, .job_pop,
    .rd_data(store_r[rd_addr]), .rd_addr, .out_vld,
    .out_byte(out_reply_byte), .out_last(out_reply_last), .out_rdy(out_pop)
  );

  assign out_empty = !out_vld;

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) |-> !cmd_vld) else $error("job queue overflow");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("bad job count");
  a_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0) |-> out_empty) else $error("reply without job");
`endif
endmodule

@@ design/mbrtu_front.sv @@
// ----------------------------------------------------------------------------
// mbrtu_front: request parser
// Collects bytes, runs the CRC, judges the frame and issues a reply job.
// ----------------------------------------------------------------------------
module mbrtu_front import mbrtu_pkg::*; #(
  parameter int REG_COUNT = 16,
  parameter int MAX_FRAME = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_vld,
  input  logic [7:0] frame_byte,
  input  logic       frame_last,
  input  logic [7:0] station,
  input  logic [3:0] lim_reg,
  input  logic [15:0] lim_max,
  output logic       cmd_vld,
  output cmd_t       cmd
);
  logic [15:0] crc_r, crc_nxt;
  logic [8:0]  cnt_r;
  logic [7:0]  addr_r, func_r;
  logic [31:0] head_r;
  logic [7:0]  addr_v, func_v;
  logic [31:0] head_v, head_m;
  logic [8:0]  len;
  logic [15:0] w0, w1;
  logic        take;
  logic [16:0] rsum;

  always_comb begin
    addr_v = (cnt_r == 9'd0) ? frame_byte : addr_r;
    func_v = (cnt_r == 9'd1) ? frame_byte : func_r;
    head_v = head_r;
    if (cnt_r >= 9'd2 && cnt_r <= 9'd5)
      head_v = head_r | ({24'd0, frame_byte} << (6'd8 * (6'd5 - 6'(cnt_r))));
    crc_nxt = crc_feed(crc_r, frame_byte);
    len = (cnt_r < 9'(MAX_FRAME + 1)) ? cnt_r + 9'd1 : cnt_r;
    head_m = head_v;
    if (len < 9'd5)      head_m = 32'd0;
    else if (len < 9'd6) head_m = head_v & 32'hFF00_0000;
    else if (len < 9'd7) head_m = head_v & 32'hFFFF_0000;
    else if (len < 9'd8) head_m = head_v & 32'hFFFF_FF00;
    w0 = head_m[31:16];
    w1 = head_m[15:0];
    rsum = {1'b0, w0} + {1'b0, w1};
    take = byte_vld && frame_last && len >= 9'd4 && len <= 9'(MAX_FRAME)
           && addr_v == station && crc_nxt == 16'd0;
    cmd.head = head_m;
    cmd.station = station;
    cmd.func = func_v;
    cmd.code = EXC_FUNCTION;
    cmd.kind = KIND_EXC;
    if (func_v == FN_READ) begin
      if (w1 == 16'd0 || w1 > 16'(READ_LIMIT) || rsum > 17'(REG_COUNT)) begin
        cmd.func = FN_READ | FN_EXC_BIT;
        cmd.code = EXC_RANGE;
      end else begin
        cmd.kind = KIND_READ;
      end
    end else if (func_v == FN_WRITE) begin
      if (w0 >= 16'(REG_COUNT)) begin
        cmd.func = FN_WRITE | FN_EXC_BIT;
        cmd.code = EXC_RANGE;
      end else if (w0 == {12'd0, lim_reg} && w1 > lim_max) begin
        cmd.func = FN_WRITE | FN_EXC_BIT;
        cmd.code = EXC_LIMIT;
      end else begin
        cmd.kind = KIND_WRITE;
      end
    end else begin
      cmd.func = func_v + FN_EXC_BIT;
    end
    cmd_vld = take;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= CRC_INIT;
      cnt_r <= '0;
      addr_r <= '0;
      func_r <= '0;
      head_r <= '0;
    end else if (byte_vld) begin
      if (frame_last) begin
        crc_r <= CRC_INIT;
        cnt_r <= '0;
        addr_r <= '0;
        func_r <= '0;
        head_r <= '0;
      end else begin
        crc_r <= crc_nxt;
        cnt_r <= len;
        addr_r <= addr_v;
        func_r <= func_v;
        head_r <= head_v;
      end
    end
  end
endmodule

@@ design/mbrtu_back.sv @@
// ----------------------------------------------------------------------------
// mbrtu_back: reply sequencer
// Streams reply bytes for one job, reading the store, appending the CRC.
// ----------------------------------------------------------------------------
module mbrtu_back import mbrtu_pkg::*; #(
  parameter int REG_COUNT = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       job_vld,
  input  cmd_t       job,
  output logic       job_pop,
  input  logic [15:0] rd_data,
  output logic [$clog2(REG_COUNT)-1:0] rd_addr,
  output logic       out_vld,
  output logic [7:0] out_byte,
  output logic       out_last,
  input  logic       out_rdy
);
  localparam int AW = $clog2(REG_COUNT);

  tx_state_t st_r, st_nxt;
  logic [5:0]  idx_r, idx_nxt;
  logic [15:0] crc_r;
  logic [5:0]  body_len;
  logic [7:0]  hdr_b, body_b;
  logic        fire;

  assign fire = out_vld && out_rdy;

  always_comb begin
    unique case (job.kind)
      KIND_READ:  body_len = 6'd1 + {job.head[4:0], 1'b0};
      KIND_WRITE: body_len = 6'd4;
      default:    body_len = 6'd1;
    endcase
    hdr_b = (idx_r == 6'd0) ? job.station : job.func;
    unique case (job.kind)
      KIND_READ: begin
        if (idx_r == 6'd0) body_b = {job.head[6:0], 1'b0};
        else body_b = idx_r[0] ? rd_data[15:8] : rd_data[7:0];
      end
      KIND_WRITE: begin
        unique case (idx_r[1:0])
          2'd0: body_b = job.head[31:24];
          2'd1: body_b = job.head[23:16];
          2'd2: body_b = job.head[15:8];
          default: body_b = job.head[7:0];
        endcase
      end
      default: body_b = job.code;
    endcase
    rd_addr = AW'(job.head[16 +: AW] + AW'((idx_r - 6'd1) >> 1));
  end

  always_comb begin
    st_nxt = st_r;
    idx_nxt = idx_r;
    unique case (st_r)
      TX_IDLE: if (job_vld) begin st_nxt = TX_HDR; idx_nxt = '0; end
      TX_HDR: if (fire) begin
        if (idx_r == 6'd1) begin st_nxt = TX_BODY; idx_nxt = '0; end
        else idx_nxt = idx_r + 6'd1;
      end
      TX_BODY: if (fire) begin
        if (idx_r == body_len - 6'd1) st_nxt = TX_CRC_LO;
        else idx_nxt = idx_r + 6'd1;
      end
      TX_CRC_LO: if (fire) st_nxt = TX_CRC_HI;
      TX_CRC_HI: if (fire) st_nxt = TX_IDLE;
      default: st_nxt = TX_IDLE;
    endcase
  end

  always_comb begin
    out_vld = 1'b0;
    out_byte = 8'd0;
    out_last = 1'b0;
    job_pop = 1'b0;
    unique case (st_r)
      TX_HDR:    begin out_vld = 1'b1; out_byte = hdr_b; end
      TX_BODY:   begin out_vld = 1'b1; out_byte = body_b; end
      TX_CRC_LO: begin out_vld = 1'b1; out_byte = crc_r[7:0]; end
      TX_CRC_HI: begin
        out_vld = 1'b1; out_byte = crc_r[15:8]; out_last = 1'b1;
        job_pop = out_rdy;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= TX_IDLE;
      idx_r <= '0;
      crc_r <= CRC_INIT;
    end else begin
      st_r <= st_nxt;
      idx_r <= idx_nxt;
      if (st_r == TX_IDLE) crc_r <= CRC_INIT;
      else if (fire && (st_r == TX_HDR || st_r == TX_BODY))
        crc_r <= crc_feed(crc_r, out_byte);
    end
  end

`ifndef SYNTH
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && out_last) |=> st_r == TX_IDLE) else $error("last not final");
  a_pop_only_end: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |-> st_r == TX_CRC_HI) else $error("early pop");
  a_start_job: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == TX_HDR) |-> job_vld) else $error("sending without job");
`endif
endmodule
